@@ design/layer_normalization_assert.svh @@
// ----------------------------------------------------------------------------
// layer normalization assertion macros
// shared assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef LAYER_NORMALIZATION_ASSERT_SVH
`define LAYER_NORMALIZATION_ASSERT_SVH

// consequent must hold in the same cycle
`define LN_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("layer normalization port check failed");

// consequent must hold in the next cycle
`define LN_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("layer normalization port check failed");

`endif

@@ design/lnorm_pkg.sv @@
// ----------------------------------------------------------------------------
// lnorm_pkg
// types and constants shared by the layer normalization modules
// ----------------------------------------------------------------------------
`default_nettype none

package lnorm_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int ROW_W      = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int EPS_W      = 16;
	localparam int ELEM_W     = 3 * DATA_WIDTH;
	localparam int SUM_W      = 23;
	localparam int MEAN_W     = 26;
	localparam int DMAG_W     = 25;
	localparam int DIV_NW     = 56;
	localparam int DIV_DW     = 25;
	localparam int SQ_W       = 50;
	localparam int SQ_STEPS   = 25;
	localparam int SQ_STEP_W  = 5;
	localparam int RCP_W      = 41;
	localparam int ACC_W      = 64;
	localparam int MX_W       = 48;
	localparam int MD_W       = 17;

	localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AFFINE_ENABLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EPSILON       = 2'd2;

	typedef enum logic [17:0] {
		S_LOAD     = 18'h00001,
		S_MEAN_GO  = 18'h00002,
		S_MEAN_WT  = 18'h00004,
		S_VAR_RD   = 18'h00008,
		S_VAR_M0   = 18'h00010,
		S_VAR_M1   = 18'h00020,
		S_VDIV_GO  = 18'h00040,
		S_VDIV_WT  = 18'h00080,
		S_SQRT     = 18'h00100,
		S_RCP_GO   = 18'h00200,
		S_RCP_WT   = 18'h00400,
		S_OUT_RD   = 18'h00800,
		S_OUT_M0   = 18'h01000,
		S_OUT_M1   = 18'h02000,
		S_OUT_M2   = 18'h04000,
		S_OUT_AFF  = 18'h08000,
		S_OUT_FMT  = 18'h10000,
		S_OUT_SEND = 18'h20000
	} lnorm_state_t;

	// one multiply-accumulate step: acc = (load ? base : acc) + x * digit << 16*shift
	typedef struct packed {
		logic              en;
		logic              load;
		logic [MX_W-1:0]   x;
		logic [MD_W-1:0]   digit;
		logic [1:0]        shift;
		logic [ACC_W-1:0]  base;
	} mac_op_t;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] dividend;
		logic [DIV_DW-1:0] divisor;
	} div_req_t;

endpackage

`default_nettype wire

@@ design/lnorm_mac.sv @@
// ----------------------------------------------------------------------------
// lnorm_mac
// shared signed multiply-accumulate, one 48x17 partial product per enabled cycle
// ----------------------------------------------------------------------------
`default_nettype none

module lnorm_mac import lnorm_pkg::*; (
	input  logic             clk,
	input  mac_op_t          op,
	output logic [ACC_W-1:0] acc
);

	logic signed [ACC_W:0]   prod;
	logic        [ACC_W-1:0] prod_sh;
	logic        [ACC_W-1:0] acc_q;

	always_comb begin
		prod = $signed(op.x) * $signed(op.digit);
		case (op.shift)
			2'd1:    prod_sh = {prod[ACC_W-17:0], 16'b0};
			2'd2:    prod_sh = {prod[ACC_W-33:0], 32'b0};
			default: prod_sh = prod[ACC_W-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (op.en) begin
			acc_q <= (op.load ? op.base : acc_q) + prod_sh;
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

@@ design/lnorm_div.sv @@
// ----------------------------------------------------------------------------
// lnorm_div
// restoring radix-2 unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module lnorm_div import lnorm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  div_req_t          req,
	output logic              done,
	output logic [DIV_NW-1:0] quotient
);

	localparam int CW = $clog2(DIV_NW);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [DIV_NW-1:0] num_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW:0]   rem_sh;
	logic [DIV_DW:0]   diff;
	logic              ge;
	logic              last;

	assign rem_sh = {rem_q, num_q[DIV_NW-1]};
	assign diff   = rem_sh - {1'b0, den_q};
	assign ge     = rem_sh >= {1'b0, den_q};
	assign last   = cnt_q == CW'(DIV_NW - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
			num_q <= {num_q[DIV_NW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

`default_nettype wire

@@ design/layer_normalization.sv @@
// ----------------------------------------------------------------------------
// layer_normalization
// fixed-point layer normalization over groups of row_length samples
// groups are handled one at a time: the input stays closed from the last word of a
//   group until its last result is taken, and affine mode adds a multiply per result;
//   the pace is set by the single shared multiplier, the bit-serial divider (three
//   divides per group) and the iterative square root
// reset: asynchronous, clears sequencer, fill count, running sum, registers
// ----------------------------------------------------------------------------
`default_nettype none

module layer_normalization import lnorm_pkg::*; #(
	parameter int MAX_LEN = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [ELEM_W-1:0]     s_tdata,   // sample, gamma, beta
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [DATA_WIDTH-1:0] m_tdata,   // normalized
	output logic                  m_tlast,   // group_last
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam logic [ROW_W-1:0] MAX_LEN_C = ROW_W'(MAX_LEN);

	// element store: sample, gamma and beta side by side
	logic [ELEM_W-1:0] elem_mem [MAX_LEN];
	logic [ELEM_W-1:0] rd_q;

	lnorm_state_t      state_q;
	logic [ROW_W-1:0]  row_len_q;
	logic              aff_q;
	logic [EPS_W-1:0]  eps_q;

	logic [ROW_W-1:0]  cnt_q;      // fill count
	logic [SUM_W-1:0]  sum_q;      // running sum of samples
	logic [ROW_W-1:0]  n_q;        // group size
	logic [ROW_W-1:0]  idx_q;      // element walk index
	logic [MEAN_W-1:0] mean_q;     // Q.8
	logic [SQ_W-1:0]   sq_v_q;     // root remainder
	logic [SQ_W-1:0]   root_q;
	logic [SQ_W-1:0]   bit_q;
	logic [SQ_STEP_W-1:0] step_q;
	logic [RCP_W-1:0]  a_q;        // 1/sqrt, Q.32
	logic [DATA_WIDTH-1:0] out_q;
	logic              last_q;

	logic [ROW_W-1:0]  len_eff;
	logic [ROW_W-1:0]  cnt_inc;
	logic              in_acc;
	logic [SUM_W-1:0]  sum_mag;
	logic [DATA_WIDTH-1:0] smp;
	logic [DATA_WIDTH-1:0] gam;
	logic [DATA_WIDTH-1:0] bet;
	logic [MEAN_W-1:0] d;
	logic [DMAG_W-1:0] d_mag;
	logic [SQ_W:0]     trial;
	logic              sq_ge;
	logic [DIV_DW-1:0] s_root;
	logic              idx_last;

	logic [ACC_W-1:0]  acc;
	logic [ACC_W-1:0]  acc_mag;
	logic [ACC_W-1:0]  r44;
	logic [ACC_W-1:0]  r32;
	logic [ACC_W-1:0]  rnd;
	logic [DATA_WIDTH-1:0] sat;

	mac_op_t           mac_op;
	div_req_t          div_req;
	logic              div_done;
	logic [DIV_NW-1:0] div_q;

	lnorm_mac u_mac (
		.clk (clk),
		.op  (mac_op),
		.acc (acc)
	);

	lnorm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_q)
	);

	// handshakes: input only while loading, output only while presenting a word
	assign s_tready  = state_q == S_LOAD;
	assign in_acc    = s_tvalid && s_tready;
	assign m_tvalid  = state_q == S_OUT_SEND;
	assign m_tdata   = out_q;
	assign m_tlast   = last_q;
	assign cfg_ready = 1'b1;

	// zero length acts as one, oversize as the store depth
	always_comb begin
		if (row_len_q == '0) begin
			len_eff = ROW_W'(1);
		end else if (row_len_q > MAX_LEN_C) begin
			len_eff = MAX_LEN_C;
		end else begin
			len_eff = row_len_q;
		end
	end

	assign cnt_inc  = cnt_q + 1'b1;
	assign sum_mag  = sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
	assign idx_last = idx_q == (n_q - 1'b1);

	// fields of the element under walk
	assign smp = rd_q[DATA_WIDTH-1:0];
	assign gam = rd_q[2*DATA_WIDTH-1:DATA_WIDTH];
	assign bet = rd_q[3*DATA_WIDTH-1:2*DATA_WIDTH];

	// deviation in Q.8
	assign d     = {{2{smp[DATA_WIDTH-1]}}, smp, 8'b0} - mean_q;
	assign d_mag = d[MEAN_W-1] ? DMAG_W'(~d + 1'b1) : d[DMAG_W-1:0];

	// integer square root step
	assign trial  = {1'b0, root_q} + {1'b0, bit_q};
	assign sq_ge  = {1'b0, sq_v_q} >= trial;
	assign s_root = root_q[DIV_DW-1:0];

	// rounding of the accumulator, halves away from zero, then saturation
	always_comb begin
		acc_mag = acc[ACC_W-1] ? (~acc + 1'b1) : acc;
		r44     = (acc_mag + (64'd1 << 43)) >> 44;
		r32     = (acc_mag + (64'd1 << 31)) >> 32;
		rnd     = aff_q ? r44 : r32;
		if (acc[ACC_W-1]) begin
			sat = (rnd > 64'd32768) ? 16'h8000 : (~rnd[DATA_WIDTH-1:0] + 1'b1);
		end else begin
			sat = (rnd > 64'd32767) ? 16'h7fff : rnd[DATA_WIDTH-1:0];
		end
	end

	// shared multiplier and divider requests
	always_comb begin
		mac_op  = '0;
		div_req = '0;
		case (state_q)
			S_MEAN_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIV_NW'({sum_mag, 9'b0}) + DIV_NW'(n_q);
				div_req.divisor  = DIV_DW'({n_q, 1'b0});
			end
			S_MEAN_WT: begin
				// clear the square sum ahead of the variance walk
				mac_op.en   = div_done;
				mac_op.load = 1'b1;
			end
			S_VAR_M0: begin
				mac_op.en    = 1'b1;
				mac_op.x     = MX_W'(d_mag);
				mac_op.digit = {1'b0, d_mag[15:0]};
			end
			S_VAR_M1: begin
				mac_op.en    = 1'b1;
				mac_op.x     = MX_W'(d_mag);
				mac_op.digit = MD_W'(d_mag[DMAG_W-1:16]);
				mac_op.shift = 2'd1;
			end
			S_VDIV_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = acc[DIV_NW-1:0];
				div_req.divisor  = DIV_DW'(n_q);
			end
			S_RCP_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIV_NW'(1) << 40;
				div_req.divisor  = (s_root == '0) ? DIV_DW'(1) : s_root;
			end
			S_OUT_M0: begin
				mac_op.en    = 1'b1;
				mac_op.load  = 1'b1;
				mac_op.x     = {{(MX_W-MEAN_W){d[MEAN_W-1]}}, d};
				mac_op.digit = {1'b0, a_q[15:0]};
			end
			S_OUT_M1: begin
				mac_op.en    = 1'b1;
				mac_op.x     = {{(MX_W-MEAN_W){d[MEAN_W-1]}}, d};
				mac_op.digit = {1'b0, a_q[31:16]};
				mac_op.shift = 2'd1;
			end
			S_OUT_M2: begin
				mac_op.en    = 1'b1;
				mac_op.x     = {{(MX_W-MEAN_W){d[MEAN_W-1]}}, d};
				mac_op.digit = MD_W'(a_q[RCP_W-1:32]);
				mac_op.shift = 2'd2;
			end
			S_OUT_AFF: begin
				// z * gamma + beta * 2^40
				mac_op.en    = 1'b1;
				mac_op.load  = 1'b1;
				mac_op.x     = acc[MX_W-1:0];
				mac_op.digit = {gam[DATA_WIDTH-1], gam};
				mac_op.base  = {{(ACC_W-DATA_WIDTH-40){bet[DATA_WIDTH-1]}}, bet, 40'b0};
			end
			default: begin
			end
		endcase
	end

	// element store
	always_ff @(posedge clk) begin
		if (in_acc) begin
			elem_mem[cnt_q[AW-1:0]] <= s_tdata;
		end
		rd_q <= elem_mem[idx_q[AW-1:0]];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_len_q <= ROW_W'(64);
			aff_q     <= 1'b1;
			eps_q     <= EPS_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ROW_LENGTH:    row_len_q <= cfg_data[ROW_W-1:0];
				CFG_AFFINE_ENABLE: aff_q     <= cfg_data[0];
				CFG_EPSILON:       eps_q     <= cfg_data[EPS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			cnt_q   <= '0;
			sum_q   <= '0;
			n_q     <= '0;
			idx_q   <= '0;
			step_q  <= '0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						cnt_q <= cnt_inc;
						sum_q <= sum_q + {{(SUM_W-DATA_WIDTH){s_tdata[DATA_WIDTH-1]}},
							s_tdata[DATA_WIDTH-1:0]};
						if (cnt_inc >= len_eff) begin
							n_q     <= cnt_inc;
							state_q <= S_MEAN_GO;
						end
					end
				end
				S_MEAN_GO: state_q <= S_MEAN_WT;
				S_MEAN_WT: begin
					if (div_done) begin
						idx_q   <= '0;
						state_q <= S_VAR_RD;
					end
				end
				S_VAR_RD: state_q <= S_VAR_M0;
				S_VAR_M0: state_q <= S_VAR_M1;
				S_VAR_M1: begin
					if (idx_last) begin
						state_q <= S_VDIV_GO;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_VAR_RD;
					end
				end
				S_VDIV_GO: state_q <= S_VDIV_WT;
				S_VDIV_WT: begin
					if (div_done) begin
						step_q  <= '0;
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					step_q <= step_q + 1'b1;
					if (step_q == SQ_STEP_W'(SQ_STEPS - 1)) begin
						state_q <= S_RCP_GO;
					end
				end
				S_RCP_GO: state_q <= S_RCP_WT;
				S_RCP_WT: begin
					if (div_done) begin
						idx_q   <= '0;
						state_q <= S_OUT_RD;
					end
				end
				S_OUT_RD:  state_q <= S_OUT_M0;
				S_OUT_M0:  state_q <= S_OUT_M1;
				S_OUT_M1:  state_q <= S_OUT_M2;
				S_OUT_M2:  state_q <= aff_q ? S_OUT_AFF : S_OUT_FMT;
				S_OUT_AFF: state_q <= S_OUT_FMT;
				S_OUT_FMT: state_q <= S_OUT_SEND;
				S_OUT_SEND: begin
					if (m_tready) begin
						if (last_q) begin
							cnt_q   <= '0;
							sum_q   <= '0;
							state_q <= S_LOAD;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_OUT_RD;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_MEAN_WT: begin
				if (div_done) begin
					mean_q <= sum_q[SUM_W-1] ? (~div_q[MEAN_W-1:0] + 1'b1) : div_q[MEAN_W-1:0];
				end
			end
			S_VDIV_WT: begin
				// variance plus epsilon, root starts at bit 48 (v stays below 2^50)
				if (div_done) begin
					sq_v_q <= {1'b0, div_q[SQ_W-2:0]} + SQ_W'({eps_q, 16'b0});
					root_q <= '0;
					bit_q  <= SQ_W'(1) << 48;
				end
			end
			S_SQRT: begin
				if (sq_ge) begin
					sq_v_q <= sq_v_q - trial[SQ_W-1:0];
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			S_RCP_WT: begin
				if (div_done) begin
					a_q <= div_q[RCP_W-1:0];
				end
			end
			S_OUT_FMT: begin
				out_q  <= sat;
				last_q <= idx_last;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

@@ design/lnorm_chk.sv @@
// ----------------------------------------------------------------------------
// lnorm_chk
// port-level checks for layer_normalization, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "layer_normalization_assert.svh"

module lnorm_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tlast
);

	// a stalled result word holds
	`LN_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
	// no input is taken while results are pending
	`LN_ASSERT_NOW(a_no_overlap, s_tready, !m_tvalid)
	// the last word of a group reopens the input
	`LN_ASSERT_NEXT(a_reopen, m_tvalid && m_tready && m_tlast, s_tready)
	// inside a group the input stays closed
	`LN_ASSERT_NEXT(a_in_group, m_tvalid && m_tready && !m_tlast, !s_tready && !m_tvalid)

endmodule

bind layer_normalization lnorm_chk u_chk (.*);

`default_nettype wire

@@ dv/layer_normalization_checker.sv @@
// ----------------------------------------------------------------------------
// layer_normalization_checker
// watches the config, input and output channels of the layer normalization
// block, predicts each normalized word and compares in arrival order
// ----------------------------------------------------------------------------
module layer_normalization_checker import lnorm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [ELEM_W-1:0]     s_tdata,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [DATA_WIDTH-1:0] m_tdata,
	input  logic                  m_tlast,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fails,
	output int                    pending
);

	localparam int GROUP_MAX = 64;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] value;
		logic                  last;
	} norm_word_t;

	norm_word_t norm_q[$];

	logic signed [15:0] smp_buf[GROUP_MAX];
	logic signed [15:0] gam_buf[GROUP_MAX];
	logic signed [15:0] bet_buf[GROUP_MAX];
	int                 fill;
	longint             acc_sum;
	logic [ROW_W-1:0]   row_len_q;
	logic               affine_q;
	logic [EPS_W-1:0]   eps_q;

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		fails++;
	endtask

	// divide by 2^k, nearest, halves away from zero
	function automatic longint round_div(input longint v, input int k);
		longint unsigned mg;
		mg = (v < 0) ? -v : v;
		mg = (mg + (64'd1 << (k - 1))) >> k;
		return (v < 0) ? -longint'(mg) : longint'(mg);
	endfunction

	function automatic longint unsigned int_root(input longint unsigned v);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (v >= root + bitv) begin
				v    = v - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	// buffer one word; when the group closes, queue all its normalized words
	function automatic void absorb_word(input logic [15:0] smp, input logic [15:0] gam,
			input logic [15:0] bet);
		int              len;
		longint unsigned mg, sq, v, rt, a, n;
		longint          mean, d, z, y;
		len = row_len_q;
		if (len == 0) len = 1;
		if (len > GROUP_MAX) len = GROUP_MAX;
		smp_buf[fill] = smp;
		gam_buf[fill] = gam;
		bet_buf[fill] = bet;
		acc_sum += longint'($signed(smp));
		fill++;
		if (fill < len) return;
		n  = fill;
		mg = (acc_sum < 0) ? -acc_sum : acc_sum;
		mg = mg << 8;
		mg = (2 * mg + n) / (2 * n);
		mean = (acc_sum < 0) ? -longint'(mg) : longint'(mg);
		sq = 0;
		for (int i = 0; i < fill; i++) begin
			d  = longint'(smp_buf[i]) * 256 - mean;
			mg = (d < 0) ? -d : d;
			sq += mg * mg;
		end
		v  = sq / n + (longint'(eps_q) << 16);
		rt = int_root(v);
		a  = (64'd1 << 40) / ((rt == 0) ? 64'd1 : rt);
		for (int i = 0; i < fill; i++) begin
			d = longint'(smp_buf[i]) * 256 - mean;
			z = d * longint'(a);
			if (affine_q)
				y = round_div(z * longint'(gam_buf[i]) + longint'(bet_buf[i]) * (64'sd1 << 40), 44);
			else
				y = round_div(z, 32);
			if (y > 32767) y = 32767;
			if (y < -32768) y = -32768;
			norm_q.push_back('{value: y[15:0], last: (i == fill - 1)});
		end
		fill    = 0;
		acc_sum = 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		norm_word_t want;
		if (!arst_n) begin
			row_len_q = 7'd64;
			affine_q  = 1'b1;
			eps_q     = 16'd1;
			fill      = 0;
			acc_sum   = 0;
			fails     = 0;
			norm_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ROW_LENGTH: row_len_q = cfg_data[ROW_W-1:0];
					CFG_AFFINE_ENABLE: affine_q = cfg_data[0];
					CFG_EPSILON: eps_q = cfg_data[EPS_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				absorb_word(s_tdata[15:0], s_tdata[31:16], s_tdata[47:32]);
			if (m_tvalid && m_tready) begin
				if (norm_q.size() == 0) begin
					report("unexpected word", m_tdata, 0);
				end else begin
					want = norm_q.pop_front();
					if (m_tdata !== want.value) report("normalized", m_tdata, want.value);
					if (m_tlast !== want.last) report("group_last", m_tlast, want.last);
				end
			end
		end
		pending = norm_q.size();
	end

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// stimulus for the layer normalization block: directed corner groups, then
// random groups across several register settings with bursty input and
// stalling output; the checker predicts and compares every word
// ----------------------------------------------------------------------------
module tb import lnorm_pkg::*;;

	localparam int RANDOM_WORDS = 230;
	localparam int CYCLE_LIMIT  = 2000000;
	localparam int SETTLE       = 400;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [ELEM_W-1:0]     s_tdata = '0;       // sample, gamma, beta
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [DATA_WIDTH-1:0] m_tdata;            // normalized
	logic                  m_tlast;            // group_last
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int                    fails;
	int                    pending;
	int                    cycles = 0;
	int                    burst_left = 0;
	int                    sent = 0;

	always #4 clk = ~clk;

	layer_normalization dut (.*);

	layer_normalization_checker chk (.*);

	// hard stop if the run hangs
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// receiver stall pattern: free running, random, or mostly stalled stretches
	int stall_phase = 0;
	always @(negedge clk) begin
		stall_phase++;
		case ((stall_phase / 97) % 3)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(1) == 1);
			default: m_tready <= ($urandom_range(3) == 0);
		endcase
	end

	// register write, held until taken
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = value[CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// one input word; valid stays high inside a burst
	task automatic send_word(input logic [15:0] smp, input logic [15:0] gam,
			input logic [15:0] bet);
		@(negedge clk);
		if (burst_left == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(6)) @(negedge clk);
			burst_left = ($urandom_range(3) == 0) ? 40 : $urandom_range(1, 12);
		end
		s_tvalid = 1'b1;
		s_tdata  = {bet, gam, smp};
		do @(posedge clk); while (!s_tready);
		burst_left--;
		sent++;
	endtask

	// drop valid, drain all expected words, let the block settle
	task automatic go_idle();
		@(negedge clk);
		s_tvalid = 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		int          len, groups, kind;
		logic [15:0] base;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// field extremes with affine on and zero epsilon
		write_reg(CFG_ROW_LENGTH, 4);
		write_reg(CFG_AFFINE_ENABLE, 1);
		write_reg(CFG_EPSILON, 0);
		send_word(16'h7fff, 16'h7fff, 16'h7fff);
		send_word(16'h8000, 16'h8000, 16'h8000);
		send_word(16'h0000, 16'h7fff, 16'h8000);
		send_word(16'hffff, 16'h8000, 16'h7fff);
		// equal samples with zero epsilon: zero root
		repeat (4) send_word(16'h0100, 16'h1000, 16'h0000);
		go_idle();

		// zero length acts as one, largest epsilon, no affine
		write_reg(CFG_AFFINE_ENABLE, 0);
		write_reg(CFG_EPSILON, 16'hffff);
		write_reg(CFG_ROW_LENGTH, 0);
		send_word(16'h8000, 16'h1234, 16'h4321);
		send_word(16'h7fff, 16'h0000, 16'h0000);
		go_idle();

		// length lowered below the buffered count mid-group
		write_reg(CFG_ROW_LENGTH, 5);
		write_reg(CFG_AFFINE_ENABLE, 1);
		send_word(16'h0200, 16'h2000, 16'h0100);
		send_word(16'hfe00, 16'h1000, 16'hff00);
		send_word(16'h0080, 16'hf000, 16'h0000);
		go_idle();
		write_reg(CFG_ROW_LENGTH, 2);
		send_word(16'h0040, 16'h1000, 16'h0800);
		go_idle();

		// random phases
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			case ($urandom_range(7))
				0: len = 1;
				1: len = 64;
				2: len = 127;   // above the limit, acts as 64
				default: len = $urandom_range(2, 16);
			endcase
			write_reg(CFG_ROW_LENGTH, len);
			write_reg(CFG_AFFINE_ENABLE, $urandom_range(1));
			case ($urandom_range(3))
				0: write_reg(CFG_EPSILON, 0);
				1: write_reg(CFG_EPSILON, 16'hffff);
				2: write_reg(CFG_EPSILON, 1);
				default: write_reg(CFG_EPSILON, $urandom_range(16'hffff));
			endcase
			if (len > 64) len = 64;
			groups = (len >= 32) ? 1 : $urandom_range(1, 3);
			for (int g = 0; g < groups; g++) begin
				kind = $urandom_range(5);
				base = 16'($urandom);
				for (int i = 0; i < len; i++) begin
					case (kind)
						0: send_word(base, 16'($urandom), 16'($urandom));   // flat group
						1: send_word(16'(base + $urandom_range(255) - 128), 16'($urandom),
							16'($urandom));
						default: send_word(16'($urandom), 16'($urandom), 16'($urandom));
					endcase
				end
			end
			// sometimes leave a partial group behind for the next setting
			if ($urandom_range(4) == 0)
				send_word(16'($urandom), 16'($urandom), 16'($urandom));
			go_idle();
		end

		if (fails == 0 && pending == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
